>>> hdl/pcent_pkg.sv
// Shared types and constants for the polygon centroid block.
`timescale 1ns / 1ps

package pcent_pkg;

	// Parameter defaults
	localparam int MAX_VERTICES_DEF = 1024;
	localparam int COORD_BITS_DEF   = 16;
	localparam int FRAC_BITS_DEF    = 8;

	// Fixed field and accumulator widths
	localparam int IN_W   = 16;
	localparam int OUT_W  = 24;
	localparam int ST_W   = 2;
	localparam int AREA_W = 45;
	localparam int NUM_W  = 62;

	// Result status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_ZERO_AREA = 2'd1,
		ST_FEW       = 2'd2,
		ST_SAT       = 2'd3
	} status_t;

	// Control into the edge accumulator
	typedef struct packed {
		logic start;
		logic clear;
	} acc_ctrl_t;

	// Status out of the divider
	typedef struct packed {
		logic done;
		logic sat;
	} div_stat_t;

endpackage

>>> hdl/pcent_accum.sv
// Edge accumulator: one shared multiplier sequenced over the shoelace terms of an edge.
`timescale 1ns / 1ps

module pcent_accum import pcent_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  acc_ctrl_t                      ctrl,
	input  logic signed [COORD_BITS-1:0]   ax,
	input  logic signed [COORD_BITS-1:0]   ay,
	input  logic signed [COORD_BITS-1:0]   bx,
	input  logic signed [COORD_BITS-1:0]   by,
	output logic                           done,
	output logic signed [AREA_W-1:0]       area,
	output logic signed [NUM_W-1:0]        wx,
	output logic signed [NUM_W-1:0]        wy
);

	localparam int SUM_W = COORD_BITS + 1;
	localparam int C_W   = 2 * COORD_BITS + 1;
	localparam int PW    = SUM_W + C_W;

	typedef enum logic [6:0] {
		A_IDLE = 7'b0000001,
		A_M1   = 7'b0000010,
		A_M2   = 7'b0000100,
		A_SUB  = 7'b0001000,
		A_MX   = 7'b0010000,
		A_MY   = 7'b0100000,
		A_ACC  = 7'b1000000
	} acc_state_t;

	acc_state_t                 state_q;
	logic signed [COORD_BITS-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [SUM_W-1:0]    sx_q, sy_q;
	logic signed [C_W-1:0]      c_q;
	logic signed [PW-1:0]       prod_q;
	logic signed [AREA_W-1:0]   area_q;
	logic signed [NUM_W-1:0]    wx_q, wy_q;
	logic                       done_q;

	logic signed [SUM_W-1:0]    mul_a;
	logic signed [C_W-1:0]      mul_b;
	logic signed [PW-1:0]       prod;

	// Operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			A_M1: begin
				mul_a = SUM_W'(ax_q);
				mul_b = C_W'(by_q);
			end
			A_M2: begin
				mul_a = SUM_W'(bx_q);
				mul_b = C_W'(ay_q);
			end
			A_MX: begin
				mul_a = sx_q;
				mul_b = c_q;
			end
			A_MY: begin
				mul_a = sy_q;
				mul_b = c_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Sequencer and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
			area_q  <= '0;
			wx_q    <= '0;
			wy_q    <= '0;
			ax_q    <= '0;
			ay_q    <= '0;
			bx_q    <= '0;
			by_q    <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			c_q     <= '0;
			prod_q  <= '0;
		end else begin
			done_q <= (state_q == A_ACC);
			prod_q <= prod;
			case (state_q)
				A_IDLE: begin
					if (ctrl.clear) begin
						area_q <= '0;
						wx_q   <= '0;
						wy_q   <= '0;
					end
					if (ctrl.start) begin
						ax_q    <= ax;
						ay_q    <= ay;
						bx_q    <= bx;
						by_q    <= by;
						sx_q    <= SUM_W'(ax) + SUM_W'(bx);
						sy_q    <= SUM_W'(ay) + SUM_W'(by);
						state_q <= A_M1;
					end
				end
				A_M1: state_q <= A_M2;
				A_M2: begin
					// ax*by is ready
					c_q     <= C_W'(prod_q);
					state_q <= A_SUB;
				end
				A_SUB: begin
					// cross term complete
					c_q     <= c_q - C_W'(prod_q);
					state_q <= A_MX;
				end
				A_MX: begin
					area_q  <= area_q + AREA_W'(c_q);
					state_q <= A_MY;
				end
				A_MY: begin
					wx_q    <= wx_q + NUM_W'(prod_q);
					state_q <= A_ACC;
				end
				A_ACC: begin
					wy_q    <= wy_q + NUM_W'(prod_q);
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign area = area_q;
	assign wx   = wx_q;
	assign wy   = wy_q;

endmodule

>>> hdl/pcent_div.sv
// Restoring divider: weighted sum * 2^FRAC_BITS / (3 * doubled area), one bit per cycle.
`timescale 1ns / 1ps

module pcent_div import pcent_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [NUM_W-1:0]  num,
	input  logic signed [AREA_W-1:0] area,
	output div_stat_t                stat,
	output logic [OUT_W-1:0]         quot
);

	localparam int DEN_W = AREA_W + 2;
	localparam int DV_W  = NUM_W + FRAC_BITS;
	localparam int SH_W  = DEN_W + OUT_W;
	localparam int RW    = (DV_W > SH_W) ? DV_W : SH_W;
	localparam int QW    = OUT_W + 1;
	localparam int STEPS = OUT_W + 1;
	localparam int SC_W  = $clog2(STEPS);
	localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (OUT_W - 1)) - 64'd1);
	localparam logic [QW-1:0] LIM_NEG = QW'(64'd1 << (OUT_W - 1));

	typedef enum logic [4:0] {
		D_IDLE = 5'b00001,
		D_MAG  = 5'b00010,
		D_LOAD = 5'b00100,
		D_ITER = 5'b01000,
		D_FIN  = 5'b10000
	} div_state_t;

	div_state_t          state_q;
	logic [NUM_W-1:0]    n_q;
	logic [AREA_W-1:0]   a_q;
	logic                neg_q;
	logic [RW-1:0]       rem_q;
	logic [RW-1:0]       dsr_q;
	logic [QW-1:0]       q_q;
	logic [SC_W-1:0]     step_q;
	logic [OUT_W-1:0]    quot_q;
	logic                done_q;
	logic                sat_q;

	logic                ge;
	logic [QW-1:0]       lim;
	logic                over;
	logic [OUT_W-1:0]    m;

	assign ge   = rem_q >= dsr_q;
	assign lim  = neg_q ? LIM_NEG : LIM_POS;
	assign over = q_q > lim;
	assign m    = over ? lim[OUT_W-1:0] : q_q[OUT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			sat_q   <= 1'b0;
			quot_q  <= '0;
			n_q     <= '0;
			a_q     <= '0;
			neg_q   <= 1'b0;
			rem_q   <= '0;
			dsr_q   <= '0;
			q_q     <= '0;
			step_q  <= '0;
		end else begin
			done_q <= (state_q == D_FIN);
			case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_MAG;
					end
					// magnitudes and quotient sign
					n_q   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
					a_q   <= area[AREA_W-1] ? AREA_W'(-area) : AREA_W'(area);
					neg_q <= num[NUM_W-1] ^ area[AREA_W-1];
				end
				D_MAG: state_q <= D_LOAD;
				D_LOAD: begin
					// dividend scaled by fraction bits, divisor 3*area at top quotient bit
					rem_q   <= RW'(n_q) << FRAC_BITS;
					dsr_q   <= (RW'(a_q) + (RW'(a_q) << 1)) << OUT_W;
					q_q     <= '0;
					step_q  <= SC_W'(STEPS - 1);
					state_q <= D_ITER;
				end
				D_ITER: begin
					if (ge) begin
						rem_q <= rem_q - dsr_q;
					end
					q_q    <= {q_q[QW-2:0], ge};
					dsr_q  <= dsr_q >> 1;
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					// saturate, then apply sign
					quot_q  <= neg_q ? (~m + 1'b1) : m;
					sat_q   <= over;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign stat.done = done_q;
	assign stat.sat  = sat_q;
	assign quot      = quot_q;

endmodule

>>> hdl/polygon_centroid.sv
// Polygon centroid top level: vertex intake, polygon sequencing and result register.
//
//  Channel  | Signals                                 | Direction
//  ---------+-----------------------------------------+----------
//  input    | in_valid, in_ready, vertex_x, vertex_y, | in
//           | last_vertex                             |
//  output   | out_valid, out_ready, centroid_x,       | out
//           | centroid_y, status                      |
//
// A vertex that adds an edge waits for the six-step pass of the shared multiplier
// over the edge terms. The first vertex of a polygon, or one past the vertex
// limit, adds no edge. The closing vertex adds the closing edge and, for three
// or more vertices and nonzero area, two 25-step divisions on the shared divider.
// in_ready is high only while the sequencer is idle. Reset clears the accumulators
// and vertex count. A waiting result holds in the output register; the next polygon
// is taken meanwhile and only a second result waits for out_ready.
`timescale 1ns / 1ps

module polygon_centroid import pcent_pkg::*; #(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [IN_W-1:0]  vertex_x,
	input  logic signed [IN_W-1:0]  vertex_y,
	input  logic                    last_vertex,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OUT_W-1:0] centroid_x,
	output logic signed [OUT_W-1:0] centroid_y,
	output logic [ST_W-1:0]         status
);

	localparam int CNT_W = $clog2(MAX_VERTICES + 1);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b00000001,
		S_EDGE  = 8'b00000010,
		S_CLOSE = 8'b00000100,
		S_CWAIT = 8'b00001000,
		S_CHECK = 8'b00010000,
		S_DIVX  = 8'b00100000,
		S_DIVY  = 8'b01000000,
		S_OUT   = 8'b10000000
	} state_t;

	state_t                       state_q;
	logic signed [COORD_BITS-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [CNT_W-1:0]             count_q;
	logic                         last_q;
	logic [OUT_W-1:0]             cx_q, cy_q;
	status_t                      st_q;
	logic                         sat_q;
	logic                         out_valid_q;
	logic [OUT_W-1:0]             out_cx_q, out_cy_q;
	status_t                      out_st_q;

	logic                         accept;
	logic                         has_edge;
	logic                         out_free;
	logic                         load_out;
	logic signed [COORD_BITS-1:0] x_in, y_in;
	logic signed [COORD_BITS-1:0] op_bx, op_by;
	acc_ctrl_t                    acc_ctrl;
	logic                         acc_done;
	logic signed [AREA_W-1:0]     area;
	logic signed [NUM_W-1:0]      wx, wy;
	logic                         div_start;
	logic signed [NUM_W-1:0]      div_num;
	div_stat_t                    div_stat;
	logic [OUT_W-1:0]             quot;

	// Intake and handshake
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign x_in     = vertex_x[COORD_BITS-1:0];
	assign y_in     = vertex_y[COORD_BITS-1:0];
	assign has_edge = (count_q != '0) && (count_q < CNT_W'(MAX_VERTICES));
	assign out_free = !out_valid_q || out_ready;
	assign load_out = (state_q == S_OUT) && out_free;

	// Edge operands: new vertex, or the first vertex on the closing edge
	assign op_bx          = (state_q == S_CLOSE) ? first_x_q : x_in;
	assign op_by          = (state_q == S_CLOSE) ? first_y_q : y_in;
	assign acc_ctrl.start = (accept && has_edge) || (state_q == S_CLOSE);
	assign acc_ctrl.clear = load_out;

	pcent_accum #(
		.COORD_BITS(COORD_BITS)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (acc_ctrl),
		.ax     (prev_x_q),
		.ay     (prev_y_q),
		.bx     (op_bx),
		.by     (op_by),
		.done   (acc_done),
		.area   (area),
		.wx     (wx),
		.wy     (wy)
	);

	// Divider runs x first, then y
	assign div_start = ((state_q == S_CHECK) && (count_q >= CNT_W'(3)) && (area != '0)) ||
	                   ((state_q == S_DIVX) && div_stat.done);
	assign div_num   = (state_q == S_DIVX) ? wy : wx;

	pcent_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.area   (area),
		.stat   (div_stat),
		.quot   (quot)
	);

	// Polygon sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			last_q      <= 1'b0;
			first_x_q   <= '0;
			first_y_q   <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			st_q        <= ST_OK;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_cx_q    <= '0;
			out_cy_q    <= '0;
			out_st_q    <= ST_OK;
		end else begin
			// result register: load wins over a drain in the same cycle
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= last_vertex;
						if (count_q == '0) begin
							first_x_q <= x_in;
							first_y_q <= y_in;
							prev_x_q  <= x_in;
							prev_y_q  <= y_in;
							count_q   <= CNT_W'(1);
						end else if (has_edge) begin
							prev_x_q <= x_in;
							prev_y_q <= y_in;
							count_q  <= count_q + 1'b1;
						end
						if (has_edge) begin
							state_q <= S_EDGE;
						end else if (last_vertex) begin
							state_q <= S_CLOSE;
						end
					end
				end
				S_EDGE: begin
					if (acc_done) begin
						state_q <= last_q ? S_CLOSE : S_IDLE;
					end
				end
				S_CLOSE: state_q <= S_CWAIT;
				S_CWAIT: begin
					if (acc_done) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					cx_q <= '0;
					cy_q <= '0;
					if (count_q < CNT_W'(3)) begin
						st_q    <= ST_FEW;
						state_q <= S_OUT;
					end else if (area == '0) begin
						st_q    <= ST_ZERO_AREA;
						state_q <= S_OUT;
					end else begin
						state_q <= S_DIVX;
					end
				end
				S_DIVX: begin
					if (div_stat.done) begin
						cx_q    <= quot;
						sat_q   <= div_stat.sat;
						state_q <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (div_stat.done) begin
						cy_q    <= quot;
						st_q    <= (sat_q || div_stat.sat) ? ST_SAT : ST_OK;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_cx_q <= cx_q;
						out_cy_q <= cy_q;
						out_st_q <= st_q;
						count_q  <= '0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign centroid_x = out_cx_q;
	assign centroid_y = out_cy_q;
	assign status     = out_st_q;

	// Edge pass finishes only while the sequencer waits for it
	a_acc_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		acc_done |-> (state_q == S_EDGE || state_q == S_CWAIT))
		else $error("edge accumulator finished outside a wait state");

	// Division finishes only while a centroid coordinate is pending
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIVX || state_q == S_DIVY))
		else $error("divider finished outside a division state");

	// Loading a result restarts the polygon and presents the item
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (count_q == '0 && out_valid_q && state_q == S_IDLE))
		else $error("result load did not restart the polygon");

endmodule
